/* sv/sts_pkg.sv */
package sts_pkg;

    // defaults for the top-level parameters
    localparam int unsigned DEPTH_DEF      = 1024;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // fixed field widths of the ports
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 10;

    // function codes of an input beat
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

endpackage

/* sv/sorted_table_search_core.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | func, value, last
// out     | output    | out_valid / out_stall| found, position
//
// a load beat writes its element to the table memory at once, unless the table is full
// a search beat makes one probe per read, as the table memory has a single read port
// the load marked last starts the sort, with one memory read per compared element
//   and two writes per swap; in_stall is high meanwhile
// reset clears the control state only; the table needs no clearing pass
// a finished result waits in the output register while the next beat is taken;
//   a second search result holds in its last state until out_stall drops
module sorted_table_search_core
    import sts_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      func,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [POS_W-1:0]          position
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_SORT_INIT  = 9'b000000010,
        ST_SORT_FIRST = 9'b000000100,
        ST_SORT_SCAN  = 9'b000001000,
        ST_SORT_SW1   = 9'b000010000,
        ST_SORT_SW2   = 9'b000100000,
        ST_SRCH_RD    = 9'b001000000,
        ST_SRCH_CMP   = 9'b010000000,
        ST_SRCH_DONE  = 9'b100000000
    } state_t;

    // table memory, one write and one registered read port
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] rdata_reg;

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           sorted_reg, sorted_next;
    logic           out_valid_reg, out_valid_next;

    // sort datapath
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         j_reg, j_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         best_reg, best_next;
    logic [DATA_WIDTH-1:0] best_val_reg, best_val_next;
    logic [DATA_WIDTH-1:0] ival_reg, ival_next;

    // search datapath; the window is [low, hiex)
    logic [CW-1:0]         low_reg, low_next;
    logic [CW-1:0]         hiex_reg, hiex_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]         mid_reg, mid_next;
    logic                  res_found_reg, res_found_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;

    // output register
    logic             found_reg, found_next;
    logic [POS_W-1:0] position_reg, position_next;

    logic [DATA_WIDTH-1:0] value_ext;
    logic [POS_W-1:0]      mid_pos;
    logic [CW-1:0]         mid_calc;
    logic [CW-1:0]         cnt_eff;
    logic                  in_beat;
    logic                  out_free;

    // fit the 32-bit key to the element width, sign extending when wider
    generate
        if (DATA_WIDTH <= VALUE_W) begin : g_val_trunc
            assign value_ext = value[DATA_WIDTH-1:0];
        end
        else begin : g_val_sext
            assign value_ext = {{(DATA_WIDTH - VALUE_W){value[VALUE_W-1]}}, value};
        end
    endgenerate

    // position carries the low bits of the index
    generate
        if (AW >= POS_W) begin : g_pos_trunc
            assign mid_pos = mid_reg[POS_W-1:0];
        end
        else begin : g_pos_zext
            assign mid_pos = {{(POS_W - AW){1'b0}}, mid_reg};
        end
    endgenerate

    // mid = low + (high - low) / 2 with high = hiex - 1
    assign mid_calc = low_reg + ((hiex_reg - low_reg - CW'(1)) >> 1);

    // a load after a finished sort starts a new table
    assign cnt_eff  = sorted_reg ? '0 : cnt_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_beat   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sorted_next    = sorted_reg;
        out_valid_next = out_valid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rd_idx_next    = rd_idx_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        ival_next      = ival_reg;
        low_next       = low_reg;
        hiex_next      = hiex_reg;
        key_next       = key_reg;
        mid_next       = mid_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = value_ext;
        mem_raddr      = '0;

        // the taken beat leaves the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        sorted_next = 1'b0;
                        cnt_next    = cnt_eff;
                        // loads beyond the table size are dropped
                        if (cnt_eff < CW'(DEPTH))
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cnt_eff[AW-1:0];
                            cnt_next  = cnt_eff + CW'(1);
                        end
                        if (last)
                        begin
                            i_next     = '0;
                            state_next = ST_SORT_INIT;
                        end
                    end
                    else
                    begin
                        key_next   = value_ext;
                        low_next   = '0;
                        hiex_next  = cnt_reg;
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SORT_INIT:
            begin
                // the last position needs no pass
                if (i_reg + CW'(1) >= cnt_reg)
                begin
                    sorted_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    mem_raddr  = i_reg[AW-1:0];
                    j_next     = i_reg + CW'(1);
                    state_next = ST_SORT_FIRST;
                end
            end
            ST_SORT_FIRST:
            begin
                ival_next     = rdata_reg;
                best_val_next = rdata_reg;
                best_next     = i_reg[AW-1:0];
                mem_raddr     = j_reg[AW-1:0];
                rd_idx_next   = j_reg[AW-1:0];
                j_next        = j_reg + CW'(1);
                state_next    = ST_SORT_SCAN;
            end
            ST_SORT_SCAN:
            begin
                // strictly smaller only, so the first minimum stays
                if ($signed(rdata_reg) < $signed(best_val_reg))
                begin
                    best_next     = rd_idx_reg;
                    best_val_next = rdata_reg;
                end
                if (j_reg < cnt_reg)
                begin
                    mem_raddr   = j_reg[AW-1:0];
                    rd_idx_next = j_reg[AW-1:0];
                    j_next      = j_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_SORT_SW1;
                end
            end
            ST_SORT_SW1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = best_reg;
                mem_wdata  = ival_reg;
                state_next = ST_SORT_SW2;
            end
            ST_SORT_SW2:
            begin
                // written second, so a self swap keeps the right value
                mem_we     = 1'b1;
                mem_waddr  = i_reg[AW-1:0];
                mem_wdata  = best_val_reg;
                i_next     = i_reg + CW'(1);
                state_next = ST_SORT_INIT;
            end
            ST_SRCH_RD:
            begin
                if (low_reg < hiex_reg)
                begin
                    mem_raddr  = mid_calc[AW-1:0];
                    mid_next   = mid_calc[AW-1:0];
                    state_next = ST_SRCH_CMP;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = ST_SRCH_DONE;
                end
            end
            ST_SRCH_CMP:
            begin
                priority if (rdata_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_pos;
                    state_next     = ST_SRCH_DONE;
                end
                else if ($signed(rdata_reg) < $signed(key_reg))
                begin
                    low_next   = CW'(mid_reg) + CW'(1);
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    hiex_next  = CW'(mid_reg);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    position_next  = res_pos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        rd_idx_reg    <= rd_idx_next;
        best_reg      <= best_next;
        best_val_reg  <= best_val_next;
        ival_reg      <= ival_next;
        low_reg       <= low_next;
        hiex_reg      <= hiex_next;
        key_reg       <= key_next;
        mid_reg       <= mid_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        found_reg     <= found_next;
        position_reg  <= position_next;
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

endmodule

/* sv/sts_checker.sv */
module sts_checker
    import sts_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      func,
    input logic                      last,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      found,
    input logic [POS_W-1:0]          position
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(found) && $stable(position))
        else $error("result payload changed while stalled");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("miss with nonzero position");

    // a search beat or the final load keeps the input side busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_SEARCH || last) |=> in_stall)
        else $error("input taken during search or sort");

    // a plain load leaves the input side free in the next cycle
    a_load_1cy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FUNC_LOAD && !last |=> !in_stall)
        else $error("plain load did not finish in one cycle");

endmodule

bind sorted_table_search_core sts_checker u_sts_checker (.*);
